### src/spid_pkg.sv
// ----------------------------------------------------------------------------
// spid_pkg - shared types, constants and saturation helpers
// Common definitions for the saturating pid controller and its arithmetic
// units.
// ----------------------------------------------------------------------------
package spid_pkg;

   localparam int DW = 32;

   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   // register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_MODE = 2'd3;

   // integration rules
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BWD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRAP = 2'd2;

   // integral area per second, time in ms
   localparam logic [DW-1:0] MS_PER_S = DW'(1000);

   typedef logic signed [DW-1:0] word_type;
   typedef logic signed [DW:0]   wide_type;

   // clamp a value one bit wider than the data path
   function automatic word_type sat_wide(input wide_type v);
      word_type r;
      if (v[DW] != v[DW-1]) begin
         r = v[DW] ? SAT_MIN : SAT_MAX;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      wide_type s;
      s = {a[DW-1], a} + {b[DW-1], b};
      return sat_wide(s);
   endfunction

   function automatic word_type sat_neg(input word_type a);
      wide_type s;
      s = (DW+1)'(0) - {a[DW-1], a};
      return sat_wide(s);
   endfunction

   // halve, truncating toward zero
   function automatic word_type half_trunc(input word_type a);
      wide_type s;
      s = {a[DW-1], a} + {{DW{1'b0}}, a[DW-1]};
      return s[DW:1];
   endfunction

endpackage

### src/saturating_pid_controller.sv
// ----------------------------------------------------------------------------
// saturating_pid_controller - integer pid with saturation and anti-windup
// Sequencer around one shared multiplier and one iterative divider.
//
//   channel   ports                               direction  handshake
//   request   req_setpoint/measured/time_ms       in         valid/ready
//   response  rsp_drive                           out        valid/ready
//   csr       csr_index, csr_wdata                in         csr_wen only
//
// Requests are taken only in the idle state, so the next item is accepted
// once the current result is in the output register. The two divisions
// (derivative by the elapsed time, integral increment by 1000) run one
// after the other on the shared divider; an item with zero error or zero
// elapsed time skips them. Reset is synchronous and clears all but the
// per-item working registers. A stalled response holds in the output register
// while the next item is accepted, whose result waits for the register.
// ----------------------------------------------------------------------------
module saturating_pid_controller
   import spid_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [DW-1:0]        req_setpoint,
   input  logic signed [DW-1:0]        req_measured,
   input  logic [DW-1:0]               req_time_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DW-1:0]        rsp_drive,
   input  logic                        csr_wen,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DW-1:0]               csr_wdata
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_CHK  = 4'd1;
   localparam logic [ST_W-1:0] S_M1   = 4'd2;
   localparam logic [ST_W-1:0] S_M2   = 4'd3;
   localparam logic [ST_W-1:0] S_M3   = 4'd4;
   localparam logic [ST_W-1:0] S_M4   = 4'd5;
   localparam logic [ST_W-1:0] S_M5   = 4'd6;
   localparam logic [ST_W-1:0] S_DW1  = 4'd7;
   localparam logic [ST_W-1:0] S_DW2  = 4'd8;
   localparam logic [ST_W-1:0] S_PD   = 4'd9;
   localparam logic [ST_W-1:0] S_FIN  = 4'd10;
   localparam logic [ST_W-1:0] S_SUM  = 4'd11;
   localparam logic [ST_W-1:0] S_OUT  = 4'd12;

   logic [ST_W-1:0] state_ff, state_in;

   // configuration
   word_type          kp_ff, ki_ff, kd_ff;
   logic [MODE_W-1:0] mode_ff;

   // persistent state
   word_type      integ_ff, integ_in;
   word_type      prev_err_ff, prev_err_in;
   logic [DW-1:0] prev_time_ff, prev_time_in;

   // per-item working registers
   word_type      err_ff, err_in;
   logic [DW-1:0] dt_ff, dt_in;
   logic [DW-1:0] now_ff, now_in;
   word_type      diff_ff, diff_in;
   word_type      esum_ff, esum_in;
   word_type      p_ff, p_in;
   word_type      d_ff, d_in;
   word_type      area_ff, area_in;
   word_type      kia_ff, kia_in;
   word_type      incr_ff, incr_in;
   word_type      pd_ff, pd_in;
   word_type      res_ff, res_in;

   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_drive_ff, rsp_drive_in;

   // shared units
   logic signed [DW:0] mul_a, mul_b;
   word_type           mul_res;
   logic               div_start;
   word_type           div_dividend;
   logic [DW-1:0]      div_divisor;
   logic               div_busy;
   word_type           div_quo;

   wide_type err_wide;
   word_type pd_sum;
   logic     accept;

   spid_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_res)
   );

   spid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign err_wide  = {req_setpoint[DW-1], req_setpoint} - {req_measured[DW-1], req_measured};
   assign pd_sum    = sat_add(p_ff, d_ff);

   // multiplier operands by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CHK: begin
            mul_a = {kp_ff[DW-1], kp_ff};
            mul_b = {err_ff[DW-1], err_ff};
         end
         S_M1: begin
            mul_a = {kd_ff[DW-1], kd_ff};
            mul_b = {diff_ff[DW-1], diff_ff};
         end
         S_M2: begin
            mul_a = {1'b0, dt_ff};
            unique case (mode_ff)
               MODE_FWD: mul_b = {prev_err_ff[DW-1], prev_err_ff};
               MODE_BWD: mul_b = {err_ff[DW-1], err_ff};
               default:  mul_b = {esum_ff[DW-1], esum_ff};
            endcase
         end
         S_M4: begin
            mul_a = {ki_ff[DW-1], ki_ff};
            mul_b = {area_ff[DW-1], area_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      integ_in     = integ_ff;
      prev_err_in  = prev_err_ff;
      prev_time_in = prev_time_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      now_in       = now_ff;
      diff_in      = diff_ff;
      esum_in      = esum_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      area_in      = area_ff;
      kia_in       = kia_ff;
      incr_in      = incr_ff;
      pd_in        = pd_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      div_start    = 1'b0;
      div_dividend = mul_res;
      div_divisor  = dt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               err_in   = sat_wide(err_wide);
               dt_in    = req_time_ms - prev_time_ff;
               now_in   = req_time_ms;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (dt_ff == '0 || err_ff == '0) begin
               res_in   = integ_ff;
               state_in = S_OUT;
            end else begin
               diff_in  = sat_add(err_ff, sat_neg(prev_err_ff));
               esum_in  = sat_add(err_ff, prev_err_ff);
               state_in = S_M1;
            end
         end
         S_M1: begin
            p_in     = mul_res;
            state_in = S_M2;
         end
         S_M2: begin
            // derivative product straight into the divider
            div_start = 1'b1;
            state_in  = S_M3;
         end
         S_M3: begin
            area_in  = (mode_ff == MODE_FWD || mode_ff == MODE_BWD) ? mul_res
                                                                  : half_trunc(mul_res);
            state_in = S_M4;
         end
         S_M4: begin
            state_in = S_M5;
         end
         S_M5: begin
            kia_in   = mul_res;
            state_in = S_DW1;
         end
         S_DW1: begin
            div_dividend = kia_ff;
            div_divisor  = MS_PER_S;
            if (!div_busy) begin
               d_in      = div_quo;
               div_start = 1'b1;
               state_in  = S_DW2;
            end
         end
         S_DW2: begin
            if (!div_busy) begin
               incr_in  = div_quo;
               state_in = S_PD;
            end
         end
         S_PD: begin
            pd_in = pd_sum;
            // anti-windup: p + d alone at a bound leaves the state alone
            if (pd_sum == SAT_MAX || pd_sum == SAT_MIN) begin
               res_in   = pd_sum;
               state_in = S_OUT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            integ_in     = sat_add(integ_ff, incr_ff);
            prev_err_in  = err_ff;
            prev_time_in = now_ff;
            state_in     = S_SUM;
         end
         S_SUM: begin
            res_in   = sat_add(pd_ff, integ_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_drive_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         prev_time_ff <= '0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         mode_ff      <= MODE_FWD;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         prev_time_ff <= prev_time_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_PROP_GAIN:  kp_ff   <= csr_wdata;
               CSR_INTEG_GAIN: ki_ff   <= csr_wdata;
               CSR_DERIV_GAIN: kd_ff   <= csr_wdata;
               CSR_INTEG_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
               default:        mode_ff <= mode_ff;
            endcase
         end
      end
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      now_ff       <= now_in;
      diff_ff      <= diff_in;
      esum_ff      <= esum_in;
      p_ff         <= p_in;
      d_ff         <= d_in;
      area_ff      <= area_in;
      kia_ff       <= kia_in;
      incr_ff      <= incr_in;
      pd_ff        <= pd_in;
      res_ff       <= res_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

### src/spid_mul.sv
// ----------------------------------------------------------------------------
// spid_mul - shared saturating multiplier
// Sign-magnitude multiply with the product registered; the saturated
// result is available in the cycle after the operands.
// ----------------------------------------------------------------------------
module spid_mul
   import spid_pkg::*;
(
   input  logic                 clock,
   input  logic signed [DW:0]   op_a,
   input  logic signed [DW:0]   op_b,
   output logic signed [DW-1:0] product
);

   localparam logic [2*DW-1:0] POS_LIM = (2*DW)'(SAT_MAX);
   localparam logic [2*DW-1:0] NEG_LIM = POS_LIM + (2*DW)'(1);

   logic [DW-1:0]   mag_a, mag_b;
   logic [DW:0]     neg_a, neg_b;
   logic [2*DW-1:0] mag_ff, mag_in;
   logic            sign_ff, sign_in;

   always_comb begin
      neg_a   = (DW+1)'(0) - op_a;
      neg_b   = (DW+1)'(0) - op_b;
      mag_a   = op_a[DW] ? neg_a[DW-1:0] : op_a[DW-1:0];
      mag_b   = op_b[DW] ? neg_b[DW-1:0] : op_b[DW-1:0];
      mag_in  = {{DW{1'b0}}, mag_a} * {{DW{1'b0}}, mag_b};
      sign_in = op_a[DW] ^ op_b[DW];
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      sign_ff <= sign_in;
   end

   always_comb begin
      if (!sign_ff) begin
         product = (mag_ff > POS_LIM) ? SAT_MAX : mag_ff[DW-1:0];
      end else if (mag_ff > NEG_LIM) begin
         product = SAT_MIN;
      end else begin
         product = ~mag_ff[DW-1:0] + DW'(1);
      end
   end

endmodule

### src/spid_div.sv
// ----------------------------------------------------------------------------
// spid_div - iterative signed-by-unsigned divider
// Restoring division, two quotient bits a cycle; quotient truncates toward
// zero. Busy from the cycle after start until the quotient is ready.
// ----------------------------------------------------------------------------
module spid_div
   import spid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] dividend,
   input  logic [DW-1:0]        divisor,
   output logic                 busy,
   output logic signed [DW-1:0] quotient
);

   localparam int STEPS = DW / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;

   logic [DW:0]   r1, r1s, r2, r2s;
   logic          ge1, ge2;
   logic [DW-1:0] q1, q2;
   logic [DW-1:0] mag_div;

   always_comb begin
      // first bit of the pair
      r1  = {rem_ff, quo_ff[DW-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1s = ge1 ? r1 - {1'b0, den_ff} : r1;
      q1  = {quo_ff[DW-2:0], ge1};
      // second bit
      r2  = {r1s[DW-1:0], q1[DW-1]};
      ge2 = r2 >= {1'b0, den_ff};
      r2s = ge2 ? r2 - {1'b0, den_ff} : r2;
      q2  = {q1[DW-2:0], ge2};

      mag_div = dividend[DW-1] ? (DW'(0) - dividend) : dividend;

      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = mag_div;
         den_in   = divisor;
         neg_in   = dividend[DW-1];
         count_in = CNT_W'(STEPS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = r2s[DW-1:0];
         quo_in   = q2;
         count_in = count_ff - CNT_W'(1);
         busy_in  = (count_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (DW'(0) - quo_ff) : quo_ff;

endmodule

### src/spid_check.sv
// ----------------------------------------------------------------------------
// spid_check - port-level checks for the saturating pid controller
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module spid_check
   import spid_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [DW-1:0] rsp_drive
);

   // no response left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an item just taken is worked on before the next is accepted
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
      else $error("request taken while an item is in progress");

   // a stalled response keeps its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("stalled response dropped or changed");

   // a response never appears in the cycle right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared with no work done");

endmodule

bind saturating_pid_controller spid_check u_spid_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive)
);
